/* rtl/lpjs_pkg.sv */
// ============================================================================
// lpjs_pkg - shared types and constants for the LED pattern job sequencer
// Request/result payload structs, job layout, job kind and color codes.
// ============================================================================
package lpjs_pkg;

    // Sizing
    localparam int QUEUE_DEPTH  = 8;
    localparam int MAX_COLORS   = 4;
    localparam int COLOR_FIELDS = 4;
    localparam int PTR_W        = $clog2(QUEUE_DEPTH);
    localparam int LVL_W        = ($clog2(QUEUE_DEPTH + 1) > 4) ? $clog2(QUEUE_DEPTH + 1) : 4;

    // Job kinds (kinds 6 and 7 are unknown and do nothing)
    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_OFF    = 3'd1;
    localparam logic [2:0] KIND_ON     = 3'd2;
    localparam logic [2:0] KIND_ON_OFF = 3'd3;
    localparam logic [2:0] KIND_ALT    = 3'd4;
    localparam logic [2:0] KIND_QUIT   = 3'd5;

    // Color codes as carried in a job, and the LED drive codes
    localparam logic [1:0] COLOR_MAX_OK = 2'd2;
    localparam logic [1:0] LED_OFF      = 2'd0;

    // Request action codes
    localparam logic ACTION_PUSH = 1'b0;
    localparam logic ACTION_TICK = 1'b1;

    // Request payload
    typedef struct packed {
        logic        action;
        logic [2:0]  job_kind;
        logic [1:0]  color_a;
        logic [1:0]  color_b;
        logic [1:0]  color_c;
        logic [1:0]  color_d;
        logic [2:0]  color_count;
        logic [15:0] step_ms;
    } in_item_t;

    // Result payload
    typedef struct packed {
        logic [1:0] led_color;
        logic       led_command;
        logic       push_refused;
        logic       stopped;
        logic [3:0] queue_level;
    } out_item_t;

    // Stored job, 30 bits
    typedef struct packed {
        logic [15:0] step_ms;
        logic [2:0]  color_count;
        logic [1:0]  color_d;
        logic [1:0]  color_c;
        logic [1:0]  color_b;
        logic [1:0]  color_a;
        logic [2:0]  job_kind;
    } job_t;

    // Request class decided by the front end
    typedef enum logic [1:0] {
        OP_IGNORE,
        OP_STORE,
        OP_TICK
    } op_t;

    typedef struct packed {
        op_t  op;
        job_t job;
    } fe_entry_t;

    // Color field i of a job
    function automatic logic [1:0] job_color(input job_t j, input logic [1:0] i);
        logic [1:0] c;
        case (i)
            2'd0:    c = j.color_a;
            2'd1:    c = j.color_b;
            2'd2:    c = j.color_c;
            default: c = j.color_d;
        endcase
        return c;
    endfunction

endpackage

/* rtl/lpjs_front.sv */
// ============================================================================
// lpjs_front - request intake
// Classifies each request and holds it in a two-entry queue for the back end.
// ============================================================================
module lpjs_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  lpjs_pkg::in_item_t   item,
    output logic                 fe_valid,
    output lpjs_pkg::fe_entry_t  fe_entry,
    input  logic                 fe_take
);
    import lpjs_pkg::*;

    fe_entry_t  slot_reg [2];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    fe_entry_t  cls;
    logic       accept;

    // Classify: tick, storable push, or push of the none kind
    always_comb
    begin
        cls.job.job_kind    = item.job_kind;
        cls.job.color_a     = item.color_a;
        cls.job.color_b     = item.color_b;
        cls.job.color_c     = item.color_c;
        cls.job.color_d     = item.color_d;
        cls.job.color_count = item.color_count;
        cls.job.step_ms     = item.step_ms;
        if (item.action == ACTION_TICK)
            cls.op = OP_TICK;
        else if (item.job_kind == KIND_NONE)
            cls.op = OP_IGNORE;
        else
            cls.op = OP_STORE;
    end

    assign full     = (cnt_reg == 2'd2);
    assign accept   = push && !full;
    assign fe_valid = (cnt_reg != 2'd0);
    assign fe_entry = slot_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept && !fe_take)
            cnt_next = cnt_reg + 2'd1;
        else if (!accept && fe_take)
            cnt_next = cnt_reg - 2'd1;
    end

    // Queue pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (accept)
                wr_reg <= !wr_reg;
            if (fe_take)
                rd_reg <= !rd_reg;
            cnt_reg <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (accept)
            slot_reg[wr_reg] <= cls;
    end

endmodule

/* rtl/lpjs_back.sv */
// ============================================================================
// lpjs_back - job FIFO and LED sequencer
// Runs one classified request per cycle while the result queue has room: stores jobs, counts ticks, runs jobs.
// ============================================================================
module lpjs_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fe_valid,
    input  lpjs_pkg::fe_entry_t  fe_entry,
    output logic                 fe_take,
    input  logic                 rq_full,
    output logic                 res_valid,
    output lpjs_pkg::out_item_t  res,
    input  logic [15:0]          idle_poll_ms
);
    import lpjs_pkg::*;

    job_t             store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] rd_reg,     rd_next;
    logic [PTR_W-1:0] wr_reg,     wr_next;
    logic [LVL_W-1:0] level_reg,  level_next;
    job_t             active_reg, active_next;
    logic             lit_reg,    lit_next;
    logic [15:0]      wait_reg,   wait_next;
    logic [1:0]       pos_reg,    pos_next;
    logic             halted_reg, halted_next;
    logic [1:0]       shown_reg,  shown_next;

    logic             go;
    logic             store_we;
    logic             refused;
    logic             cmd;
    logic             mid_alt;
    logic             do_pop;
    job_t             job;
    logic [1:0]       pos_cur;
    logic [1:0]       col;
    logic [3:0]       n4;
    logic [2:0]       n3;
    logic [2:0]       pos_p1;
    logic [15:0]      delay;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] s);
        return (s == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : s + PTR_W'(1);
    endfunction

    assign go        = fe_valid && !rq_full;
    assign fe_take   = go;
    assign res_valid = go;

    // Sequencer step
    always_comb
    begin
        rd_next     = rd_reg;
        wr_next     = wr_reg;
        level_next  = level_reg;
        active_next = active_reg;
        lit_next    = lit_reg;
        wait_next   = wait_reg;
        pos_next    = pos_reg;
        halted_next = halted_reg;
        shown_next  = shown_reg;
        store_we    = 1'b0;
        refused     = 1'b0;
        cmd         = 1'b0;
        delay       = 16'd0;
        col         = 2'd0;
        pos_p1      = 3'd0;

        // Pass candidates: pop a stored job, if any, unless an alternate sequence is mid-way
        mid_alt = (active_reg.job_kind == KIND_ALT) && (pos_reg != 2'd0);
        do_pop  = (level_reg != '0) && !mid_alt;
        job     = do_pop ? store_reg[rd_reg] : active_reg;
        pos_cur = do_pop ? 2'd0 : pos_reg;

        // Alternate color count, clamped
        n4 = {1'b0, job.color_count};
        if (n4 > 4'(MAX_COLORS))
            n4 = 4'(MAX_COLORS);
        if (n4 > 4'(COLOR_FIELDS))
            n4 = 4'(COLOR_FIELDS);
        n3 = n4[2:0];

        if (go)
        begin
            case (fe_entry.op)
                OP_STORE:
                begin
                    if (level_reg == LVL_W'(QUEUE_DEPTH))
                        refused = 1'b1;
                    else
                    begin
                        store_we   = 1'b1;
                        wr_next    = next_slot(wr_reg);
                        level_next = level_reg + LVL_W'(1);
                    end
                end
                OP_TICK:
                begin
                    if (!halted_reg)
                    begin
                        if (wait_reg != 16'd0)
                            wait_next = wait_reg - 16'd1;
                        else
                        begin
                            if (do_pop)
                            begin
                                rd_next    = next_slot(rd_reg);
                                level_next = level_reg - LVL_W'(1);
                            end
                            active_next = job;
                            pos_next    = pos_cur;
                            case (job.job_kind)
                                KIND_NONE:
                                    delay = idle_poll_ms;
                                KIND_OFF:
                                begin
                                    shown_next = LED_OFF;
                                    cmd        = 1'b1;
                                end
                                KIND_ON:
                                begin
                                    col = job.color_a;
                                    if (col <= COLOR_MAX_OK)
                                    begin
                                        shown_next = col + 2'd1;
                                        cmd        = 1'b1;
                                    end
                                    active_next = '0;
                                end
                                KIND_ON_OFF:
                                begin
                                    if (lit_reg)
                                    begin
                                        shown_next = LED_OFF;
                                        cmd        = 1'b1;
                                        lit_next   = 1'b0;
                                    end
                                    else
                                    begin
                                        col = job.color_a;
                                        if (col <= COLOR_MAX_OK)
                                        begin
                                            shown_next = col + 2'd1;
                                            cmd        = 1'b1;
                                        end
                                        lit_next = 1'b1;
                                    end
                                    delay = job.step_ms;
                                end
                                KIND_ALT:
                                begin
                                    if (n3 != 3'd0)
                                    begin
                                        if ({1'b0, pos_cur} >= n3)
                                            pos_cur = 2'd0;
                                        col = job_color(job, pos_cur);
                                        if (col <= COLOR_MAX_OK)
                                        begin
                                            shown_next = col + 2'd1;
                                            cmd        = 1'b1;
                                        end
                                        delay  = job.step_ms;
                                        pos_p1 = {1'b0, pos_cur} + 3'd1;
                                        pos_next = (pos_p1 >= n3) ? 2'd0 : pos_p1[1:0];
                                    end
                                    else
                                        pos_next = 2'd0;
                                end
                                KIND_QUIT:
                                    halted_next = 1'b1;
                                default:
                                    delay = 16'd0;
                            endcase
                            wait_next = (delay == 16'd0) ? 16'd0 : delay - 16'd1;
                        end
                    end
                end
                default:
                    refused = 1'b0;
            endcase
        end

        res.led_color    = shown_next;
        res.led_command  = cmd;
        res.push_refused = refused;
        res.stopped      = halted_next;
        res.queue_level  = level_next[3:0];
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg     <= '0;
            wr_reg     <= '0;
            level_reg  <= '0;
            active_reg <= '0;
            lit_reg    <= 1'b0;
            wait_reg   <= 16'd0;
            pos_reg    <= 2'd0;
            halted_reg <= 1'b0;
            shown_reg  <= LED_OFF;
        end
        else
        begin
            rd_reg     <= rd_next;
            wr_reg     <= wr_next;
            level_reg  <= level_next;
            active_reg <= active_next;
            lit_reg    <= lit_next;
            wait_reg   <= wait_next;
            pos_reg    <= pos_next;
            halted_reg <= halted_next;
            shown_reg  <= shown_next;
        end
    end

    // Job storage
    always_ff @(posedge clk)
    begin
        if (store_we)
            store_reg[wr_reg] <= fe_entry.job;
    end

`ifndef SYNTH
    // Queue never holds more jobs than it has slots
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LVL_W'(QUEUE_DEPTH))
        else $error("job queue level out of range");

    // Quit is permanent
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halted state cleared");

    // A refused push only happens on a full queue
    a_refuse_full: assert property (@(posedge clk) disable iff (!rst_n)
        (go && res.push_refused) |-> (level_reg == LVL_W'(QUEUE_DEPTH)))
        else $error("push refused with room in queue");

    // A color position in progress belongs to an alternate job
    a_pos_alt: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg != 2'd0) |-> (active_reg.job_kind == KIND_ALT))
        else $error("color position set outside alternate job");
`endif

endmodule

/* rtl/lpjs_result_q.sv */
// ============================================================================
// lpjs_result_q - result queue
// Two-entry queue that holds results until the receiver pops them.
// ============================================================================
module lpjs_result_q (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  lpjs_pkg::out_item_t  wr_data,
    output logic                 rq_full,
    input  logic                 pop,
    output logic                 empty,
    output lpjs_pkg::out_item_t  rd_data
);
    import lpjs_pkg::*;

    out_item_t  slot_reg [2];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       do_rd;
    logic       do_wr;

    assign rq_full = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign rd_data = slot_reg[rd_reg];
    assign do_wr   = wr_en && !rq_full;
    assign do_rd   = pop && !empty;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 2'd1;
        else if (!do_wr && do_rd)
            cnt_next = cnt_reg - 2'd1;
    end

    // Pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_wr)
                wr_reg <= !wr_reg;
            if (do_rd)
                rd_reg <= !rd_reg;
            cnt_reg <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_reg] <= wr_data;
    end

endmodule

/* rtl/led_pattern_job_sequencer_top.sv */
// ============================================================================
// led_pattern_job_sequencer_top - tri-color status LED job sequencer
// Request queue in, result queue out, APB register for the idle poll time.
// ============================================================================
// Usage:
//   Requests enter through push/full with the payload on item. A request is
//   either a job push or a one-millisecond tick. Every request gives exactly
//   one result, read through empty/pop from the result port, in order.
//   Jobs wait in an 8-deep FIFO; a push to a full FIFO is reported with
//   push_refused. Ticks count down the current wait and run the next job.
//   Timing: an accepted request is classified and registered in a two-entry
//   front queue; the sequencer runs it from there once the result queue has
//   room, and its result is registered in the result queue. The sequencer
//   finishes one request per cycle, so a request may be pushed every cycle
//   while results are popped every cycle.
//   Backpressure: when pop stays low the two-entry result queue fills, the
//   sequencer stops, the front queue fills and full goes high; nothing lost.
//   Reset: FIFO empty, LED off, no job active, not stopped, idle poll 500.
//   idle_poll_ms sits at byte address 0; the user must write it only while idle (unenforced).
// ============================================================================
module led_pattern_job_sequencer_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  lpjs_pkg::in_item_t   item,
    input  logic                 pop,
    output logic                 empty,
    output lpjs_pkg::out_item_t  result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import lpjs_pkg::*;

    localparam logic REG_IDLE_POLL = 1'b0;

    fe_entry_t   fe_entry;
    logic        fe_valid;
    logic        fe_take;
    logic        rq_full;
    logic        res_valid;
    out_item_t   res;
    logic [15:0] idle_poll_reg;
    logic        cfg_we;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_IDLE_POLL);
    assign prdata = (paddr[2] == REG_IDLE_POLL) ? {16'd0, idle_poll_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_poll_reg <= 16'd500;
        else if (cfg_we)
            idle_poll_reg <= pwdata[15:0];
    end

    // Request intake
    lpjs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .fe_valid (fe_valid),
        .fe_entry (fe_entry),
        .fe_take  (fe_take)
    );

    // Job FIFO and sequencer
    lpjs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .fe_valid     (fe_valid),
        .fe_entry     (fe_entry),
        .fe_take      (fe_take),
        .rq_full      (rq_full),
        .res_valid    (res_valid),
        .res          (res),
        .idle_poll_ms (idle_poll_reg)
    );

    // Result queue
    lpjs_result_q u_result_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res),
        .rq_full (rq_full),
        .pop     (pop),
        .empty   (empty),
        .rd_data (result)
    );

endmodule
